// ===== hdl/hnfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hnfd_pkg: shared types and constants of the half-node flux derivative unit
// Register codes, result kinds, queue item and coefficient constants.
// ----------------------------------------------------------------------------
package hnfd_pkg;

  localparam int LINE_MAX_DEFAULT   = 1024;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam int SAMPLE_W   = 32;
  localparam int WINDOW_LEN = 6;
  localparam int POINT_W    = 10;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int SUM_W      = 60;
  localparam int OPA_W      = 38;
  localparam int DIFF_W     = 33;
  localparam int MAG_W      = 36;

  // register codes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GHOST_LAYERS        = 3'd0,
    REG_INTERIOR_POINTS     = 3'd1,
    REG_LINE_POINTS         = 3'd2,
    REG_INVERSE_SPACING     = 3'd3,
    REG_LOW_CLOSURE_ENABLE  = 3'd4,
    REG_HIGH_CLOSURE_ENABLE = 3'd5
  } reg_index_t;

  // register reset values
  localparam logic [3:0]  RST_GHOST_LAYERS    = 4'd3;
  localparam logic [9:0]  RST_INTERIOR_POINTS = 10'd64;
  localparam logic [10:0] RST_LINE_POINTS     = 11'd70;
  localparam logic [31:0] RST_INVERSE_SPACING = 32'd65536;

  // result kinds, in output order within one item
  typedef enum logic [2:0] {
    KIND_LOW1     = 3'd0,
    KIND_LOW2     = 3'd1,
    KIND_INTERIOR = 3'd2,
    KIND_HIGH3    = 3'd3,
    KIND_HIGH4    = 3'd4
  } kind_t;

  localparam int KIND_COUNT = 5;

  // coefficients, 24 fraction bits
  localparam logic signed [SUM_W-1:0] COEF_75_64  = 60'sd19660800;
  localparam logic signed [SUM_W-1:0] COEF_25_384 = 60'sd1092267;
  localparam logic signed [SUM_W-1:0] COEF_3_640  = 60'sd78643;
  localparam logic signed [SUM_W-1:0] COEF_1_24   = 60'sd699051;

  localparam logic [SAMPLE_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [SAMPLE_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic [WINDOW_LEN-1:0][SAMPLE_W-1:0] win;
    logic [KIND_COUNT-1:0]               mask;
    logic [POINT_W-1:0]                  point;
    logic                                line_end;
  } job_t;

  typedef struct packed {
    logic [31:0]        inverse_spacing;
    logic [POINT_W-1:0] last_point;
  } cfg_t;

  typedef struct packed {
    logic [POINT_W-1:0] point;
    logic               last_of_item;
    logic               line_done;
  } tag_t;

endpackage

// ===== hdl/half_node_flux_derivative_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_node_flux_derivative_unit: staggered sixth-order flux derivative
// Takes the half-node flux samples of a grid line in order and delivers the
// derivative at whole points, with optional fourth-order boundary closures.
//
// Input: push a flux_sample while full is low; one sample per clock is taken
// as long as the item queue (QUEUE_DEPTH entries, four by default) has room.
// Config: cfg_valid with cfg_index and cfg_data, always ready; write only
// while no results are pending.
// Results: while empty is low the oldest result sits on derivative,
// point_index, last_of_item and line_done; pop takes it.
// Flow: a taken sample that yields results is queued as one item; the back
// pipeline issues one result per cycle while not stalled, and an item of
// one to three results leaves the queue when its last result is issued.
// Stall: a held result freezes the back pipeline; the queue keeps taking
// samples until it fills, then full rises.
// Reset: registers go to their defaults, window and position clear,
// queue and pipeline empty.
// ----------------------------------------------------------------------------
module half_node_flux_derivative_unit #(
  parameter int LINE_MAX    = hnfd_pkg::LINE_MAX_DEFAULT,
  parameter int QUEUE_DEPTH = hnfd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  logic signed [hnfd_pkg::SAMPLE_W-1:0] flux_sample,
  output logic                                full,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hnfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [hnfd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [hnfd_pkg::SAMPLE_W-1:0] derivative,
  output logic [hnfd_pkg::POINT_W-1:0]        point_index,
  output logic                                last_of_item,
  output logic                                line_done
);

  localparam int JOB_W = $bits(hnfd_pkg::job_t);

  logic                q_full;
  logic                q_valid;
  logic                q_pop;
  logic                job_push;
  hnfd_pkg::job_t      job;
  hnfd_pkg::job_t      head;
  hnfd_pkg::cfg_t      cfg;
  logic [JOB_W-1:0]    q_wr_data;
  logic [JOB_W-1:0]    q_rd_data;
  logic                out_valid;
  logic [hnfd_pkg::SAMPLE_W-1:0] deriv_bits;

  assign full        = q_full;
  assign cfg_ready   = 1'b1;
  assign empty       = !out_valid;
  assign q_wr_data   = JOB_W'(job);
  assign head        = hnfd_pkg::job_t'(q_rd_data);
  assign derivative  = $signed(deriv_bits);

  hnfd_front #(
    .LINE_MAX (LINE_MAX)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .flux_sample (flux_sample),
    .q_full      (q_full),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .job_push    (job_push),
    .job         (job),
    .cfg         (cfg)
  );

  hnfd_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (q_wr_data),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .valid   (q_valid)
  );

  hnfd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .head_valid   (q_valid),
    .head_pop     (q_pop),
    .pop          (pop),
    .out_valid    (out_valid),
    .derivative   (deriv_bits),
    .point_index  (point_index),
    .last_of_item (last_of_item),
    .line_done    (line_done)
  );

endmodule

// ===== hdl/hnfd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hnfd_queue: small synchronous queue
// Register-based queue between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
module hnfd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = hnfd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_wr;
  logic do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== hdl/hnfd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hnfd_front: sample intake and result planning
// Holds the registers, the six-sample window and the line position, and
// queues one item per sample that produces results.
// ----------------------------------------------------------------------------
module hnfd_front #(
  parameter int LINE_MAX = hnfd_pkg::LINE_MAX_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  logic [hnfd_pkg::SAMPLE_W-1:0]       flux_sample,
  input  logic                                q_full,
  input  logic                                cfg_valid,
  input  logic [hnfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [hnfd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                job_push,
  output hnfd_pkg::job_t                      job,
  output hnfd_pkg::cfg_t                      cfg
);

  localparam int POS_W = $clog2(LINE_MAX);
  localparam int LEN_W = $clog2(LINE_MAX + 1);
  localparam int CMP_W = (LEN_W > 11) ? LEN_W : 11;

  logic [3:0]  ghost_layers;
  logic [9:0]  interior_points;
  logic [10:0] line_points;
  logic [31:0] inverse_spacing;
  logic        low_closure_enable;
  logic        high_closure_enable;

  logic [hnfd_pkg::WINDOW_LEN-1:0][hnfd_pkg::SAMPLE_W-1:0] window;
  logic [POS_W-1:0] position;

  logic [hnfd_pkg::WINDOW_LEN-1:0][hnfd_pkg::SAMPLE_W-1:0] win_shift;
  logic [CMP_W-1:0] lp_c;
  logic [CMP_W-1:0] len_c;
  logic [CMP_W-1:0] last_c;
  logic [CMP_W-1:0] s_c;
  logic [CMP_W-1:0] g_c;
  logic [CMP_W-1:0] ip_c;
  logic [CMP_W-1:0] pt_c;
  logic             in_line;
  logic             at_three;
  logic             at_four;
  logic             line_end_here;
  logic             future;
  logic             accept;
  logic [hnfd_pkg::KIND_COUNT-1:0] mask;

  always_comb begin
    lp_c = CMP_W'(line_points);
    if (lp_c < CMP_W'(8)) begin
      len_c = CMP_W'(8);
    end else if (lp_c > CMP_W'(LINE_MAX)) begin
      len_c = CMP_W'(LINE_MAX);
    end else begin
      len_c = lp_c;
    end
    last_c = len_c - CMP_W'(2);
    s_c    = CMP_W'(position);
    g_c    = CMP_W'(ghost_layers);
    ip_c   = CMP_W'(interior_points);
    pt_c   = s_c - CMP_W'(2);

    in_line       = (s_c <= last_c);
    at_three      = (s_c == CMP_W'(3));
    at_four       = (s_c == CMP_W'(4));
    line_end_here = (s_c >= last_c);

    mask = '0;
    mask[hnfd_pkg::KIND_LOW1] = low_closure_enable && at_four && in_line;
    mask[hnfd_pkg::KIND_LOW2] = low_closure_enable && at_three && in_line;
    mask[hnfd_pkg::KIND_INTERIOR] = in_line && (s_c >= g_c + CMP_W'(2))
                                  && (s_c < g_c + ip_c + CMP_W'(2))
                                  && !(low_closure_enable && (at_three || at_four));
    mask[hnfd_pkg::KIND_HIGH3] = high_closure_enable && (s_c == last_c);
    mask[hnfd_pkg::KIND_HIGH4] = high_closure_enable && (s_c == last_c);

    // any result still to come later on this line
    future = (high_closure_enable && (s_c < last_c))
          || (low_closure_enable && (s_c < CMP_W'(4)))
          || ((ip_c != '0) && (g_c + CMP_W'(2) <= last_c) && (s_c < last_c)
              && (s_c <= g_c + ip_c));
  end

  assign win_shift = {window[hnfd_pkg::WINDOW_LEN-2:0], flux_sample};
  assign accept    = push && !q_full;
  assign job_push  = accept && (mask != '0);

  assign job.win      = win_shift;
  assign job.mask     = mask;
  assign job.point    = pt_c[hnfd_pkg::POINT_W-1:0];
  assign job.line_end = !future;

  assign cfg.inverse_spacing = inverse_spacing;
  assign cfg.last_point      = last_c[hnfd_pkg::POINT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ghost_layers        <= hnfd_pkg::RST_GHOST_LAYERS;
      interior_points     <= hnfd_pkg::RST_INTERIOR_POINTS;
      line_points         <= hnfd_pkg::RST_LINE_POINTS;
      inverse_spacing     <= hnfd_pkg::RST_INVERSE_SPACING;
      low_closure_enable  <= 1'b0;
      high_closure_enable <= 1'b0;
      window              <= '0;
      position            <= '0;
    end else begin
      if (cfg_valid) begin
        case (hnfd_pkg::reg_index_t'(cfg_index))
          hnfd_pkg::REG_GHOST_LAYERS:        ghost_layers        <= cfg_data[3:0];
          hnfd_pkg::REG_INTERIOR_POINTS:     interior_points     <= cfg_data[9:0];
          hnfd_pkg::REG_LINE_POINTS:         line_points         <= cfg_data[10:0];
          hnfd_pkg::REG_INVERSE_SPACING:     inverse_spacing     <= cfg_data;
          hnfd_pkg::REG_LOW_CLOSURE_ENABLE:  low_closure_enable  <= cfg_data[0];
          hnfd_pkg::REG_HIGH_CLOSURE_ENABLE: high_closure_enable <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        if (line_end_here) begin
          window   <= '0;
          position <= '0;
        end else begin
          window   <= win_shift;
          position <= position + POS_W'(1);
        end
      end
    end
  end

endmodule

// ===== hdl/hnfd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hnfd_back: stencil arithmetic pipeline
// Walks the queued item's results one per cycle, while no held result stalls
// it, through operand, coefficient product, rounding, spacing product and saturation stages.
// ----------------------------------------------------------------------------
module hnfd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  hnfd_pkg::cfg_t                cfg,
  input  hnfd_pkg::job_t                head,
  input  logic                          head_valid,
  output logic                          head_pop,
  input  logic                          pop,
  output logic                          out_valid,
  output logic [hnfd_pkg::SAMPLE_W-1:0] derivative,
  output logic [hnfd_pkg::POINT_W-1:0]  point_index,
  output logic                          last_of_item,
  output logic                          line_done
);

  localparam int KC = hnfd_pkg::KIND_COUNT;

  logic adv;
  logic issue;

  logic [KC-1:0] done_mask;
  logic [KC-1:0] cur;
  logic [KC-1:0] sel;
  logic [KC-1:0] rest;
  hnfd_pkg::kind_t kind;

  logic signed [hnfd_pkg::OPA_W-1:0]  e [hnfd_pkg::WINDOW_LEN];
  logic signed [hnfd_pkg::OPA_W-1:0]  opa;
  logic signed [hnfd_pkg::DIFF_W-1:0] d1;
  logic signed [hnfd_pkg::DIFF_W-1:0] d2;
  logic                               is_int;
  hnfd_pkg::tag_t                     tag0;

  // stage registers
  logic                               v1, v2, v3, v4;
  hnfd_pkg::tag_t                     t1, t2, t3, t4;
  logic signed [hnfd_pkg::OPA_W-1:0]  s1_opa;
  logic signed [hnfd_pkg::DIFF_W-1:0] s1_d1;
  logic signed [hnfd_pkg::DIFF_W-1:0] s1_d2;
  logic                               s1_is_int;
  logic signed [hnfd_pkg::SUM_W-1:0]  s2_a, s2_b, s2_c;
  logic [hnfd_pkg::MAG_W-1:0]         s3_b;
  logic                               s3_neg;
  logic [63:0]                        s4_lo;
  logic [35:0]                        s4_hi;
  logic                               s4_neg;

  logic signed [hnfd_pkg::SUM_W-1:0]  sum;
  logic [hnfd_pkg::SUM_W-1:0]         mag;
  logic [hnfd_pkg::SUM_W-1:0]         rnd;
  logic [64:0]                        rt;
  logic [52:0]                        r;
  logic [hnfd_pkg::SAMPLE_W-1:0]      res;

  assign adv   = !out_valid || pop;
  assign issue = head_valid && adv;

  // pick the lowest pending result of the head item
  always_comb begin
    cur  = head.mask & ~done_mask;
    kind = hnfd_pkg::KIND_INTERIOR;
    for (int i = KC - 1; i >= 0; i--) begin
      if (cur[i]) begin
        kind = hnfd_pkg::kind_t'(3'(i));
      end
    end
    sel  = KC'(1) << kind;
    rest = cur & ~sel;
  end

  assign head_pop = issue && (rest == '0);

  always_comb begin
    for (int k = 0; k < hnfd_pkg::WINDOW_LEN; k++) begin
      e[k] = $signed(head.win[k]);
    end
    opa    = '0;
    d1     = '0;
    d2     = '0;
    is_int = 1'b0;
    tag0.point        = head.point;
    tag0.last_of_item = (rest == '0);
    tag0.line_done    = (rest == '0) && head.line_end;
    case (kind)
      hnfd_pkg::KIND_INTERIOR: begin
        opa    = e[2] - e[3];
        d1     = hnfd_pkg::DIFF_W'(e[1] - e[4]);
        d2     = hnfd_pkg::DIFF_W'(e[0] - e[5]);
        is_int = 1'b1;
      end
      hnfd_pkg::KIND_LOW1: begin
        opa = e[0] - 38'sd5 * e[1] + 38'sd9 * e[2] + 38'sd17 * e[3] - 38'sd22 * e[4];
        tag0.point = 10'd1;
      end
      hnfd_pkg::KIND_LOW2: begin
        opa = e[3] - 38'sd27 * e[2] + 38'sd27 * e[1] - e[0];
        tag0.point = 10'd2;
      end
      hnfd_pkg::KIND_HIGH3: begin
        opa = e[3] - 38'sd27 * e[2] + 38'sd27 * e[1] - e[0];
        tag0.point = cfg.last_point - 10'd1;
      end
      hnfd_pkg::KIND_HIGH4: begin
        opa = 38'sd22 * e[0] - 38'sd17 * e[1] - 38'sd9 * e[2] + 38'sd5 * e[3] - e[4];
        tag0.point = cfg.last_point;
      end
      default: ;
    endcase
  end

  always_comb begin
    sum = s2_a - s2_b + s2_c;
    mag = sum[hnfd_pkg::SUM_W-1] ? hnfd_pkg::SUM_W'(-sum) : hnfd_pkg::SUM_W'(sum);
    rnd = mag + (hnfd_pkg::SUM_W'(1) << 23);
  end

  always_comb begin
    rt = 65'(s4_lo) + (65'(1) << 15);
    r  = 53'(rt[64:16]) + {1'b0, s4_hi, 16'b0};
    if (s4_neg) begin
      if (r > 53'(hnfd_pkg::SAT_NEG)) begin
        res = hnfd_pkg::SAT_NEG;
      end else begin
        res = 32'd0 - r[31:0];
      end
    end else begin
      if (r > 53'(hnfd_pkg::SAT_POS)) begin
        res = hnfd_pkg::SAT_POS;
      end else begin
        res = r[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_mask <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        done_mask <= (rest == '0) ? '0 : (done_mask | sel);
      end
      if (adv) begin
        v1        <= head_valid;
        v2        <= v1;
        v3        <= v2;
        v4        <= v3;
        out_valid <= v4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1        <= tag0;
      s1_opa    <= opa;
      s1_d1     <= d1;
      s1_d2     <= d2;
      s1_is_int <= is_int;

      t2   <= t1;
      s2_a <= s1_is_int ? hnfd_pkg::SUM_W'(s1_opa) * hnfd_pkg::COEF_75_64
                        : hnfd_pkg::SUM_W'(s1_opa) * hnfd_pkg::COEF_1_24;
      s2_b <= hnfd_pkg::SUM_W'(s1_d1) * hnfd_pkg::COEF_25_384;
      s2_c <= hnfd_pkg::SUM_W'(s1_d2) * hnfd_pkg::COEF_3_640;

      t3     <= t2;
      s3_b   <= rnd[hnfd_pkg::SUM_W-1:24];
      s3_neg <= sum[hnfd_pkg::SUM_W-1];

      t4     <= t3;
      s4_lo  <= 64'(s3_b[31:0]) * 64'(cfg.inverse_spacing);
      s4_hi  <= 36'(s3_b[35:32]) * 36'(cfg.inverse_spacing);
      s4_neg <= s3_neg;

      derivative   <= res;
      point_index  <= t4.point;
      last_of_item <= t4.last_of_item;
      line_done    <= t4.line_done;
    end
  end

endmodule

// ===== bench/flux_derivative_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flux_derivative_checker: result predictor and in-order comparator
// Watches the sample, register and result channels of the half-node flux
// derivative unit. It keeps its own copy of the registers, the six-sample
// window and the line position, works out the results of every accepted
// sample and compares each popped result field by field with the oldest
// expected one.
// ----------------------------------------------------------------------------
module flux_derivative_checker #(
  parameter int LINE_LIMIT = hnfd_pkg::LINE_MAX_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  input  logic                                 full,
  input  logic signed [hnfd_pkg::SAMPLE_W-1:0] flux_sample,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [hnfd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [hnfd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 empty,
  input  logic                                 pop,
  input  logic signed [hnfd_pkg::SAMPLE_W-1:0] derivative,
  input  logic [hnfd_pkg::POINT_W-1:0]         point_index,
  input  logic                                 last_of_item,
  input  logic                                 line_done,
  output int                                   mismatch_count,
  output int                                   pending
);
  import hnfd_pkg::*;

  localparam longint K_INNER = COEF_75_64;
  localparam longint K_MID   = COEF_25_384;
  localparam longint K_OUTER = COEF_3_640;
  localparam longint K_EDGE  = COEF_1_24;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] derivative;
    logic [POINT_W-1:0]         point;
    logic                       last_of_item;
    logic                       line_done;
  } flux_result_t;

  typedef struct packed {
    logic [1:0]               count;
    kind_t [2:0]              kind;
    logic [2:0][POINT_W-1:0]  point;
  } point_plan_t;

  logic [3:0]         ghost_layers_q;
  logic [9:0]         interior_points_q;
  logic [10:0]        line_points_q;
  logic [31:0]        inverse_spacing_q;
  logic               low_closure_q;
  logic               high_closure_q;
  longint             flux_window [WINDOW_LEN];
  logic [POINT_W-1:0] sample_pos;
  flux_result_t       expected_results [$];
  int                 mismatches = 0;

  assign mismatch_count = mismatches;

  function automatic int line_length();
    int n;
    n = int'(line_points_q);
    if (n < 8) n = 8;
    if (n > LINE_LIMIT) n = LINE_LIMIT;
    return n;
  endfunction

  // points emitted by the sample at position s, ascending
  function automatic point_plan_t plan_for(input int s);
    point_plan_t pl;
    int          len;
    int          p;
    pl = '0;
    len = line_length();
    if (s > len - 2) return pl;
    if (low_closure_q && s == 4) begin
      pl.kind[pl.count] = KIND_LOW1;
      pl.point[pl.count] = POINT_W'(1);
      pl.count = pl.count + 2'd1;
    end
    if (low_closure_q && s == 3) begin
      pl.kind[pl.count] = KIND_LOW2;
      pl.point[pl.count] = POINT_W'(2);
      pl.count = pl.count + 2'd1;
    end
    if (s >= 2) begin
      p = s - 2;
      if (p >= int'(ghost_layers_q) && p - int'(ghost_layers_q) < int'(interior_points_q) &&
          !(low_closure_q && (p == 1 || p == 2))) begin
        pl.kind[pl.count] = KIND_INTERIOR;
        pl.point[pl.count] = POINT_W'(p);
        pl.count = pl.count + 2'd1;
      end
    end
    if (high_closure_q && s == len - 2) begin
      pl.kind[pl.count] = KIND_HIGH3;
      pl.point[pl.count] = POINT_W'(len - 3);
      pl.count = pl.count + 2'd1;
      pl.kind[pl.count] = KIND_HIGH4;
      pl.point[pl.count] = POINT_W'(len - 2);
      pl.count = pl.count + 2'd1;
    end
    return pl;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: flux derivative mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : track
    flux_result_t got;
    flux_result_t want;
    point_plan_t  pl;
    point_plan_t  ahead;
    longint       sum;
    logic [63:0]  mag;
    logic [63:0]  q16;
    logic [63:0]  spacing;
    logic [63:0]  r;
    bit           neg;
    bit           line_ends_here;
    int           s;
    int           last;
    int           cnt;
    if (rst) begin
      ghost_layers_q    = RST_GHOST_LAYERS;
      interior_points_q = RST_INTERIOR_POINTS;
      line_points_q     = RST_LINE_POINTS;
      inverse_spacing_q = RST_INVERSE_SPACING;
      low_closure_q     = 1'b0;
      high_closure_q    = 1'b0;
      foreach (flux_window[i]) flux_window[i] = 0;
      sample_pos = '0;
      expected_results.delete();
      pending <= 0;
    end else begin
      if (pop && !empty) begin
        got = {derivative, point_index, last_of_item, line_done};
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result for point %0d with none expected", point_index));
        end else begin
          want = expected_results.pop_front();
          if (got.derivative !== want.derivative)
            report_mismatch($sformatf("point %0d: derivative %h, expected %h",
                                      want.point, got.derivative, want.derivative));
          if (got.point !== want.point)
            report_mismatch($sformatf("point_index %0d, expected %0d", got.point, want.point));
          if (got.last_of_item !== want.last_of_item)
            report_mismatch($sformatf("point %0d: last_of_item %b, expected %b",
                                      want.point, got.last_of_item, want.last_of_item));
          if (got.line_done !== want.line_done)
            report_mismatch($sformatf("point %0d: line_done %b, expected %b",
                                      want.point, got.line_done, want.line_done));
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_GHOST_LAYERS:        ghost_layers_q    = cfg_data[3:0];
          REG_INTERIOR_POINTS:     interior_points_q = cfg_data[9:0];
          REG_LINE_POINTS:         line_points_q     = cfg_data[10:0];
          REG_INVERSE_SPACING:     inverse_spacing_q = cfg_data;
          REG_LOW_CLOSURE_ENABLE:  low_closure_q     = cfg_data[0];
          REG_HIGH_CLOSURE_ENABLE: high_closure_q    = cfg_data[0];
          default: ;
        endcase
      end

      if (push && !full) begin
        for (int i = WINDOW_LEN - 1; i > 0; i--) flux_window[i] = flux_window[i-1];
        flux_window[0] = longint'(flux_sample);
        s = int'(sample_pos);
        last = line_length() - 2;
        pl = plan_for(s);
        cnt = int'(pl.count);
        line_ends_here = (cnt != 0);
        if (line_ends_here) begin
          for (int t = s + 1; t <= last; t++) begin
            ahead = plan_for(t);
            if (ahead.count != 0) begin
              line_ends_here = 1'b0;
              break;
            end
          end
        end
        for (int k = 0; k < cnt; k++) begin
          case (pl.kind[k])
            KIND_INTERIOR:
              sum = K_INNER * (flux_window[2] - flux_window[3])
                  - K_MID * (flux_window[1] - flux_window[4])
                  + K_OUTER * (flux_window[0] - flux_window[5]);
            KIND_LOW1:
              sum = K_EDGE * (-22 * flux_window[4] + 17 * flux_window[3] + 9 * flux_window[2]
                              - 5 * flux_window[1] + flux_window[0]);
            KIND_LOW2:
              sum = K_EDGE * (flux_window[3] - 27 * flux_window[2] + 27 * flux_window[1]
                              - flux_window[0]);
            KIND_HIGH3:
              sum = K_EDGE * (-flux_window[0] + 27 * flux_window[1] - 27 * flux_window[2]
                              + flux_window[3]);
            default:
              sum = K_EDGE * (22 * flux_window[0] - 17 * flux_window[1] - 9 * flux_window[2]
                              + 5 * flux_window[3] - flux_window[4]);
          endcase
          // round to q16.16, scale by the spacing, round again and saturate
          neg = (sum < 0);
          mag = neg ? 64'(-sum) : 64'(sum);
          q16 = (mag + 64'd8388608) >> 24;
          spacing = {32'd0, inverse_spacing_q};
          r = (((q16 & 64'hFFFF_FFFF) * spacing + 64'd32768) >> 16)
            + (((q16 >> 32) * spacing) << 16);
          if (neg) begin
            if (r > 64'h8000_0000) r = 64'h8000_0000;
            r = 64'h1_0000_0000 - r;
          end else if (r > 64'h7FFF_FFFF) begin
            r = 64'h7FFF_FFFF;
          end
          want.derivative   = r[31:0];
          want.point        = pl.point[k];
          want.last_of_item = (k == cnt - 1);
          want.line_done    = (k == cnt - 1) && line_ends_here;
          expected_results.push_back(want);
        end
        if (s >= last) begin
          sample_pos = '0;
          foreach (flux_window[i]) flux_window[i] = 0;
        end else begin
          sample_pos = sample_pos + 1'b1;
        end
      end

      pending <= expected_results.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench of the half-node flux derivative unit
// Streams flux samples along grid lines of many lengths and register
// settings, with random idling on both sides, a long result stall and
// drain pauses before every register change. A separate checker predicts
// and compares all results; this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import hnfd_pkg::*;

  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 35;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       push = 1'b0;
  logic signed [SAMPLE_W-1:0] flux_sample = '0;
  logic                       cfg_valid = 1'b0;
  logic [CFG_INDEX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  logic                       pop = 1'b0;
  logic                       full;
  logic                       cfg_ready;
  logic                       empty;
  logic signed [SAMPLE_W-1:0] derivative;
  logic [POINT_W-1:0]         point_index;
  logic                       last_of_item;
  logic                       line_done;

  int mismatch_count;
  int pending;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_flip = 1'b0;
  int line_len = 70;
  int line_pos = 0;
  int items_sent = 0;
  int stalled_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  half_node_flux_derivative_unit dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .flux_sample  (flux_sample),
    .full         (full),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .empty        (empty),
    .pop          (pop),
    .derivative   (derivative),
    .point_index  (point_index),
    .last_of_item (last_of_item),
    .line_done    (line_done)
  );

  flux_derivative_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .flux_sample    (flux_sample),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .empty          (empty),
    .pop            (pop),
    .derivative     (derivative),
    .point_index    (point_index),
    .last_of_item   (last_of_item),
    .line_done      (line_done),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles == WATCHDOG_LIMIT) begin
      $display("half_node_flux_derivative_unit regression: fail");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // result side: random idling, plus a long hold-off on request
  initial begin : drain_results
    int hold_left;
    bit seen_flip;
    hold_left = 0;
    seen_flip = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_flip != seen_flip) begin
        seen_flip = hold_flip;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= !rst && ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic [31:0] rand_flux();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3, 4: return 32'($urandom_range(0, 524288)) - 32'd262144;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_flux(input logic [31:0] value);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    flux_sample <= value;
    do @(posedge clk); while (full);
    items_sent++;
    if (line_pos >= line_len - 2) line_pos = 0;
    else line_pos++;
  endtask

  task automatic write_reg(input reg_index_t index, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (index == REG_LINE_POINTS) begin
      line_len = int'(value[10:0]);
      if (line_len < 8) line_len = 8;
      if (line_len > LINE_MAX_DEFAULT) line_len = LINE_MAX_DEFAULT;
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int target;
    int segment_len;
    logic [31:0] line_value;
    logic [31:0] spacing_value;
    logic [31:0] interior_value;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // shortest line, both closures, largest spacing, extreme samples
    write_reg(REG_GHOST_LAYERS, 32'd3);
    write_reg(REG_INTERIOR_POINTS, 32'd1008);
    write_reg(REG_LINE_POINTS, 32'd0);
    write_reg(REG_INVERSE_SPACING, 32'hFFFF_FFFF);
    write_reg(REG_LOW_CLOSURE_ENABLE, 32'd1);
    write_reg(REG_HIGH_CLOSURE_ENABLE, 32'd1);
    cfg_valid <= 1'b0;
    send_flux(32'h7FFF_FFFF);
    send_flux(32'h8000_0000);
    send_flux(32'h0000_0000);
    send_flux(32'hFFFF_FFFF);
    send_flux(32'h0000_0001);
    send_flux(32'h7FFF_FFFF);
    send_flux(32'h8000_0000);

    // overlong line clamped, single interior point, then line cut short
    wait_idle();
    write_reg(REG_GHOST_LAYERS, 32'd8);
    write_reg(REG_INTERIOR_POINTS, 32'd1);
    write_reg(REG_LINE_POINTS, 32'd2047);
    write_reg(REG_INVERSE_SPACING, 32'd65536);
    write_reg(REG_LOW_CLOSURE_ENABLE, 32'd0);
    write_reg(REG_HIGH_CLOSURE_ENABLE, 32'd0);
    cfg_valid <= 1'b0;
    repeat (11) send_flux(rand_flux());
    wait_idle();
    write_reg(REG_LINE_POINTS, 32'd8);
    cfg_valid <= 1'b0;
    // first item lands past the new line end, then a line with no results
    repeat (8) send_flux(rand_flux());

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct <= (phase == 0) ? 23 : (phase == 1) ? 82 : 0;
      rx_idle_pct <= (phase == 0) ? 82 : (phase == 1) ? 23 : 0;
      target = items_sent + PHASE_ITEMS;
      if (phase == 2) begin
        // results held back long enough to back up the input
        wait_idle();
        write_reg(REG_GHOST_LAYERS, 32'd3);
        write_reg(REG_INTERIOR_POINTS, 32'd1008);
        write_reg(REG_LINE_POINTS, 32'd64);
        write_reg(REG_INVERSE_SPACING, $urandom());
        write_reg(REG_LOW_CLOSURE_ENABLE, 32'd1);
        write_reg(REG_HIGH_CLOSURE_ENABLE, 32'd1);
        cfg_valid <= 1'b0;
        hold_flip <= !hold_flip;
        repeat (30) send_flux(rand_flux());
      end
      while (items_sent < target) begin
        wait_idle();
        case ($urandom_range(0, 7))
          0: line_value = $urandom_range(0, 7);
          1: line_value = $urandom_range(1025, 2047);
          2: line_value = 32'd1024;
          3: line_value = $urandom_range(31, 64);
          default: line_value = $urandom_range(8, 30);
        endcase
        case ($urandom_range(0, 4))
          0: spacing_value = 32'd0;
          1: spacing_value = 32'hFFFF_FFFF;
          2: spacing_value = 32'd65536;
          3: spacing_value = $urandom_range(1, 1 << 20);
          default: spacing_value = $urandom();
        endcase
        case ($urandom_range(0, 5))
          0: interior_value = 32'd1;
          1: interior_value = 32'd1008;
          default: interior_value = $urandom_range(1, 40);
        endcase
        write_reg(REG_LINE_POINTS, line_value);
        write_reg(REG_GHOST_LAYERS, $urandom_range(3, 8));
        write_reg(REG_INTERIOR_POINTS, interior_value);
        write_reg(REG_INVERSE_SPACING, spacing_value);
        write_reg(REG_LOW_CLOSURE_ENABLE, $urandom_range(0, 1));
        write_reg(REG_HIGH_CLOSURE_ENABLE, $urandom_range(0, 1));
        cfg_valid <= 1'b0;
        if (line_len > 64) segment_len = $urandom_range(1, 30);
        else if ($urandom_range(0, 4) == 0) segment_len = $urandom_range(1, line_len - 2);
        else segment_len = 0;
        if (segment_len != 0) begin
          repeat (segment_len) send_flux(rand_flux());
        end else begin
          // finish the line in progress, then maybe one more whole line
          repeat ($urandom_range(1, 2)) do send_flux(rand_flux()); while (line_pos != 0);
        end
      end
    end

    wait_idle();
    if (mismatch_count == 0 && pending == 0) begin
      $display("half_node_flux_derivative_unit regression: pass");
    end else begin
      $display("half_node_flux_derivative_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/hnfd_pkg.sv
hdl/hnfd_queue.sv
hdl/hnfd_front.sv
hdl/hnfd_back.sv
hdl/half_node_flux_derivative_unit.sv
bench/flux_derivative_checker.sv
bench/tb.sv
